### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the synchronous active-low reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: cond at an edge requires expr at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, (cond) |-> (expr), msg)

`endif

### rtl/asnp_pkg.sv
// ---------------------------------------------------------------------------
// asnp_pkg
// Shared constants, types and helpers of the SNP column marker.
// ---------------------------------------------------------------------------
package asnp_pkg;

    localparam int GENOME_DEPTH = 65536;
    localparam int ADDR_W       = (GENOME_DEPTH > 1) ? $clog2(GENOME_DEPTH) : 1;
    localparam int COLUMN_W     = 16;
    localparam int BASE_W       = 8;
    localparam int COUNT_W      = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [BASE_W-1:0] CH_GAP  = 8'h2D;
    localparam logic [BASE_W-1:0] CH_N    = 8'h4E;
    localparam logic [BASE_W-1:0] CH_STAR = 8'h2A;
    localparam logic [BASE_W-1:0] CH_LC_A = 8'h61;
    localparam logic [BASE_W-1:0] CH_LC_Z = 8'h7A;
    localparam logic [BASE_W-1:0] CASE_OFS = 8'h20;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPARE = 1'b1
    } op_t;

    // Transaction held in the read-modify-write stage
    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [BASE_W-1:0] base;
    } item_t;

    // Write-back request to the column store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BASE_W-1:0] data;
    } wr_t;

    // One result transaction
    typedef struct packed {
        logic [BASE_W-1:0]  column_base;
        logic               column_variable;
        logic               newly_marked;
        logic [COUNT_W-1:0] site_count;
    } result_t;

    function automatic logic [BASE_W-1:0] upcase(input logic [BASE_W-1:0] c);
        logic [BASE_W-1:0] r;
        r = c;
        if (c >= CH_LC_A && c <= CH_LC_Z) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

endpackage

### rtl/asnp_ram.sv
// ---------------------------------------------------------------------------
// asnp_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module asnp_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int WIDTH  = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/asnp_update.sv
// ---------------------------------------------------------------------------
// asnp_update
// Modify step of the column read-modify-write: bypass, base rules, counter.
// ---------------------------------------------------------------------------
module asnp_update (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asnp_pkg::item_t               item,
    input  logic [asnp_pkg::BASE_W-1:0]   rd_data,
    input  logic                          advance,
    output asnp_pkg::result_t             result,
    output asnp_pkg::wr_t                 wr
);
    import asnp_pkg::*;

    logic               byp_valid_reg;
    logic [ADDR_W-1:0]  byp_addr_reg;
    logic [BASE_W-1:0]  byp_data_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [BASE_W-1:0]  ref_char;
    logic [BASE_W-1:0]  ub;
    logic [BASE_W-1:0]  r_fix;
    logic [BASE_W-1:0]  new_char;
    logic               mark;
    logic               hit;

    always_comb begin
        // Take the last write when it hit the same column the RAM just read
        ref_char = (byp_valid_reg && byp_addr_reg == item.addr) ? byp_data_reg : rd_data;
        ub       = upcase(item.base);

        if ((ref_char == CH_GAP && item.base != CH_GAP) ||
            (upcase(ref_char) == CH_N && item.base != CH_N)) begin
            r_fix = ub;
        end else begin
            r_fix = ref_char;
        end

        mark = (r_fix != CH_STAR) && (item.base != CH_GAP) && (ub != CH_N) && (r_fix != ub);

        unique case (item.op)
            OP_LOAD: begin
                new_char = ub;
                hit      = 1'b0;
            end
            OP_COMPARE: begin
                new_char = mark ? CH_STAR : r_fix;
                hit      = mark && item.in_range;
            end
            default: begin
                new_char = ub;
                hit      = 1'b0;
            end
        endcase

        count_next = (hit && count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        if (item.in_range) begin
            result.column_base     = new_char;
            result.column_variable = (new_char == CH_STAR);
            result.newly_marked    = hit;
            result.site_count      = count_next;
        end else begin
            result.column_base     = '0;
            result.column_variable = 1'b0;
            result.newly_marked    = 1'b0;
            result.site_count      = count_reg;
        end

        wr.en   = advance && item.in_range;
        wr.addr = item.addr;
        wr.data = new_char;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else if (advance) begin
            count_reg <= count_next;
            if (wr.en) begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            byp_addr_reg <= wr.addr;
            byp_data_reg <= wr.data;
        end
    end

endmodule

### rtl/alignment_snp_column_marker.sv
// ---------------------------------------------------------------------------
// alignment_snp_column_marker
// Marks alignment columns as SNP sites from a stream of loaded reference
// bases and compared sample bases, keeping a running site count.
// ---------------------------------------------------------------------------
//
//   Channel  Prefix  Fields                                   Per transaction
//   input    s_      operation, column, base                  one base
//   result   m_      column_base, column_variable,            one result
//                    newly_marked, site_count
//
// One transaction is accepted per cycle when the result side keeps up; each
// input is registered, then its result. The rate is set by the single read
// port and single write port of the column RAM: each transaction reads its
// column on accept and writes it back as it leaves the read-modify-write
// stage. Back-to-back hits on one column are served by a write bypass
// register. Synchronous active-low reset clears the pipeline valids and the
// site count; the column RAM needs no clearing pass. A stalled result holds
// the read-modify-write stage, which in turn holds s_ready low.
// ---------------------------------------------------------------------------
module alignment_snp_column_marker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [asnp_pkg::COLUMN_W-1:0]  s_column,
    input  logic [asnp_pkg::BASE_W-1:0]    s_base,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [asnp_pkg::BASE_W-1:0]    m_column_base,
    output logic                           m_column_variable,
    output logic                           m_newly_marked,
    output logic [asnp_pkg::COUNT_W-1:0]   m_site_count
);
    import asnp_pkg::*;

    // Read-modify-write stage
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    item_t             s1_item_next;
    logic              s1_advance;

    // Result register
    logic              m_valid_reg;
    result_t           out_reg;

    logic              s_accept;
    logic              in_range;
    logic [BASE_W-1:0] rd_data;
    result_t           result;
    wr_t               wr;

    // Advance the stage whenever the result register is free or draining
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // Drop columns beyond the store depth: no write, no count
    assign in_range = (32'(s_column) < 32'(GENOME_DEPTH));

    always_comb begin
        s1_item_next.op       = op_t'(s_operation);
        s1_item_next.in_range = in_range;
        s1_item_next.addr     = ADDR_W'(s_column);
        s1_item_next.base     = s_base;
    end

    asnp_ram #(
        .DEPTH  (GENOME_DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (BASE_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (s_accept),
        .rd_addr (s1_item_next.addr),
        .rd_data (rd_data)
    );

    asnp_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (s1_item_reg),
        .rd_data (rd_data),
        .advance (s1_advance),
        .result  (result),
        .wr      (wr)
    );

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= s1_item_next;
        end
        if (s1_advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_column_base     = out_reg.column_base;
    assign m_column_variable = out_reg.column_variable;
    assign m_newly_marked    = out_reg.newly_marked;
    assign m_site_count      = out_reg.site_count;

endmodule

### rtl/asnp_checker.sv
// ---------------------------------------------------------------------------
// asnp_checker
// Port-level checks of the SNP column marker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module asnp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_operation,
    input logic [asnp_pkg::COLUMN_W-1:0]  s_column,
    input logic [asnp_pkg::BASE_W-1:0]    s_base,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [asnp_pkg::BASE_W-1:0]    m_column_base,
    input logic                           m_column_variable,
    input logic                           m_newly_marked,
    input logic [asnp_pkg::COUNT_W-1:0]   m_site_count
);
    import asnp_pkg::*;

    logic                        stall;
    logic [BASE_W+COUNT_W+1:0]   payload;
    logic                        var_ok;
    logic                        mark_seen;
    logic                        mark_ok;
    logic                        mark_taken;
    logic                        count_ok;
    logic [COUNT_W-1:0]          last_count_reg;

    assign stall      = m_valid && !m_ready;
    assign payload    = {m_column_base, m_column_variable, m_newly_marked, m_site_count};
    assign var_ok     = (m_column_variable == (m_column_base == CH_STAR));
    assign mark_seen  = m_valid && m_newly_marked;
    assign mark_ok    = m_column_variable && (m_site_count != '0);
    assign mark_taken = m_valid && m_ready && m_newly_marked;
    assign count_ok   = !m_valid || (m_site_count >= last_count_reg);

    // Hold the count of the last accepted result
    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) begin
            last_count_reg <= m_site_count;
        end
    end

    // A stalled result holds
    `ASSERT_CLK(a_hold, aclk, aresetn, stall |=> (m_valid && $stable(payload)), "result moved")

    // Variable flag tracks the star character
    `ASSERT_IMPL(a_var_star, aclk, aresetn, m_valid, var_ok, "variable flag wrong")

    // A new marking leaves a star and a nonzero count
    `ASSERT_IMPL(a_mark_star, aclk, aresetn, mark_seen, mark_ok, "mark without star")

    // The site count never goes backwards after a marking
    `ASSERT_CLK(a_count_up, aclk, aresetn, mark_taken |=> count_ok, "count went back")

endmodule

bind alignment_snp_column_marker asnp_checker u_asnp_checker (.*);

### tb/testbench.sv
// ---------------------------------------------------------------------------
// SNP column marker testbench
// Drives load and compare transactions into the column marker and checks
// every result against a cycle-free prediction of the column store and the
// running site count. A directed pass covers the corner cases. A random pass
// over a small pool of columns follows, with idle cycles on both channels
// and a long stretch with no idling.
// ---------------------------------------------------------------------------

class snp_site_scoreboard;

    logic [asnp_pkg::BASE_W-1:0]  column_chars [int];
    logic [asnp_pkg::COUNT_W-1:0] site_total;
    asnp_pkg::result_t            expected_columns [$];
    int                           errors;

    function new();
        site_total = '0;
        errors     = 0;
    endfunction

    function automatic logic [asnp_pkg::BASE_W-1:0] to_upper(logic [asnp_pkg::BASE_W-1:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // Apply one accepted transaction to the column store and queue its result.
    function void predict_base(asnp_pkg::op_t op, logic [asnp_pkg::COLUMN_W-1:0] col,
                               logic [asnp_pkg::BASE_W-1:0] b);
        logic [asnp_pkg::BASE_W-1:0] ub;
        logic [asnp_pkg::BASE_W-1:0] r;
        logic                        marked;
        asnp_pkg::result_t           res;
        ub     = to_upper(b);
        marked = 1'b0;
        if (op == asnp_pkg::OP_LOAD) begin
            r = ub;
        end else begin
            r = column_chars.exists(col) ? column_chars[col] : '0;
            if ((r == asnp_pkg::CH_GAP && b != asnp_pkg::CH_GAP) ||
                (to_upper(r) == asnp_pkg::CH_N && b != asnp_pkg::CH_N)) begin
                r = ub;
            end
            if (r != asnp_pkg::CH_STAR && b != asnp_pkg::CH_GAP &&
                ub != asnp_pkg::CH_N && r != ub) begin
                r      = asnp_pkg::CH_STAR;
                marked = 1'b1;
                if (site_total != asnp_pkg::COUNT_MAX) begin
                    site_total = site_total + 1'b1;
                end
            end
        end
        column_chars[col]   = r;
        res.column_base     = r;
        res.column_variable = (r == asnp_pkg::CH_STAR);
        res.newly_marked    = marked;
        res.site_count      = site_total;
        expected_columns.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
            errors++;
        end
    endfunction

    function void check_column_result(asnp_pkg::result_t got);
        asnp_pkg::result_t exp;
        if (expected_columns.size() == 0) begin
            $display("%0t: unexpected result, actual base %0h count %0h",
                     $time, got.column_base, got.site_count);
            errors++;
            return;
        end
        exp = expected_columns.pop_front();
        compare_field("column_base", exp.column_base, got.column_base);
        compare_field("column_variable", exp.column_variable, got.column_variable);
        compare_field("newly_marked", exp.newly_marked, got.newly_marked);
        compare_field("site_count", exp.site_count, got.site_count);
    endfunction

endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import asnp_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int POOL_SIZE     = 24;
    localparam int DRAIN_CYCLES  = 8;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_operation = 1'b0;
    logic [COLUMN_W-1:0] s_column    = '0;
    logic [BASE_W-1:0]   s_base      = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [BASE_W-1:0]   m_column_base;
    logic                m_column_variable;
    logic                m_newly_marked;
    logic [COUNT_W-1:0]  m_site_count;

    // Suppress idling on both channels while set.
    bit steady = 1'b0;
    int quiet_cycles = 0;

    snp_site_scoreboard sb = new();

    // Columns already loaded by the stimulus; compares only target these.
    bit                  column_loaded [int];
    logic [COLUMN_W-1:0] column_pool [POOL_SIZE];
    logic [COLUMN_W-1:0] last_column = '0;

    alignment_snp_column_marker DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_column          (s_column),
        .s_base            (s_base),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_column_base     (m_column_base),
        .m_column_variable (m_column_variable),
        .m_newly_marked    (m_newly_marked),
        .m_site_count      (m_site_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stall the result channel about 27 percent of the time unless steady.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 27);
    end

    // Sample both channels at the rising edge: note accepted inputs in the
    // predictor, check accepted results against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.predict_base(op_t'(s_operation), s_column, s_base);
            end
            if (m_valid && m_ready) begin
                sb.check_column_result('{m_column_base, m_column_variable,
                                         m_newly_marked, m_site_count});
            end
        end
    end

    // Watchdog: end the run when no transaction moves on either channel for
    // too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one transaction from a falling edge and hold it until accepted.
    // Return at the falling edge after the handshake.
    task automatic send_base(op_t op, logic [COLUMN_W-1:0] col, logic [BASE_W-1:0] b);
        while (!steady && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_column    <= col;
        s_base      <= b;
        if (op == OP_LOAD) begin
            column_loaded[col] = 1'b1;
        end
        last_column = col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly nucleotide letters of either case plus N, gap and star; the rest
    // arbitrary bytes.
    function automatic logic [BASE_W-1:0] pick_base();
        string letters;
        letters = "ACGTacgtNn-*";
        if ($urandom_range(99) < 70) begin
            return letters[$urandom_range(letters.len() - 1)];
        end
        return BASE_W'($urandom_range(255));
    endfunction

    task automatic send_random_base();
        logic [COLUMN_W-1:0] col;
        op_t                 op;
        // Revisit the previous column often to hit back-to-back updates.
        if ($urandom_range(99) < 30) begin
            col = last_column;
        end else begin
            col = column_pool[$urandom_range(POOL_SIZE - 1)];
        end
        if (!column_loaded.exists(col) || $urandom_range(99) < 30) begin
            op = OP_LOAD;
        end else begin
            op = OP_COMPARE;
        end
        send_base(op, col, pick_base());
    endtask

    initial begin
        // Hold reset low from the start, release at a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: match, lowercase mismatch marks, star column stays put.
        send_base(OP_LOAD,    16'h0000, "A");
        send_base(OP_COMPARE, 16'h0000, "A");
        send_base(OP_COMPARE, 16'h0000, "c");
        send_base(OP_COMPARE, 16'h0000, "G");
        // Gap reference: gap keeps it, lowercase n fills it with N, then a
        // real base replaces the N, then a different base marks.
        send_base(OP_LOAD,    16'hFFFF, "-");
        send_base(OP_COMPARE, 16'hFFFF, "-");
        send_base(OP_COMPARE, 16'hFFFF, "n");
        send_base(OP_COMPARE, 16'hFFFF, "t");
        send_base(OP_COMPARE, 16'hFFFF, "A");
        // Gap replaced by an incoming star: variable but not counted.
        send_base(OP_LOAD,    16'h00FF, "-");
        send_base(OP_COMPARE, 16'h00FF, "*");
        // Loaded star reads as variable without a new mark.
        send_base(OP_LOAD,    16'h8000, "*");
        send_base(OP_COMPARE, 16'h8000, "A");
        // Lowercase load, then gap and N sample bases, then an odd byte.
        send_base(OP_LOAD,    16'h5555, "g");
        send_base(OP_COMPARE, 16'h5555, "-");
        send_base(OP_COMPARE, 16'h5555, "N");
        send_base(OP_COMPARE, 16'h5555, 8'hFF);
        // Extreme byte values.
        send_base(OP_LOAD,    16'hAAAA, 8'h00);
        send_base(OP_COMPARE, 16'hAAAA, 8'h00);
        send_base(OP_COMPARE, 16'hAAAA, 8'h80);
        // Reload a marked column and compare again.
        send_base(OP_LOAD,    16'h0000, "a");
        send_base(OP_COMPARE, 16'h0000, "a");

        // Random: a small pool of columns so compares land on loaded entries.
        for (int i = 0; i < POOL_SIZE; i++) begin
            column_pool[i] = COLUMN_W'($urandom_range(16'hFFFF));
        end
        column_pool[0] = 16'h0000;
        column_pool[1] = 16'hFFFF;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Hold a stretch with no idling in the middle of the random pass.
            steady = (i >= 150 && i < 250);
            send_random_base();
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        // Drain outstanding results, then allow a few cycles for strays.
        while (sb.expected_columns.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
